// ===== hw/rtl/bkf_pkg.sv =====
// bkf_pkg: shared types, codes and the value size table of the bson key finder
// no dependencies; imported by bson_key_finder, bson_key_checker and bson_key_finder_test
`default_nettype none

package bkf_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_W         = 8 * MAX_KEY_BYTES;
	localparam int OFFS_W        = 31;
	localparam int POS_W         = 32;

	// walk phases
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SIZE = 3'd1,
		PH_TYPE = 3'd2,
		PH_NAME = 3'd3,
		PH_LEN  = 3'd4,
		PH_SKIP = 3'd5
	} phase_t;

	// result status codes
	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

	// element type codes
	localparam logic [7:0] T_DOUBLE    = 8'h01;
	localparam logic [7:0] T_STRING    = 8'h02;
	localparam logic [7:0] T_DOCUMENT  = 8'h03;
	localparam logic [7:0] T_ARRAY     = 8'h04;
	localparam logic [7:0] T_BINARY    = 8'h05;
	localparam logic [7:0] T_OBJECTID  = 8'h07;
	localparam logic [7:0] T_BOOL      = 8'h08;
	localparam logic [7:0] T_DATETIME  = 8'h09;
	localparam logic [7:0] T_NULL      = 8'h0A;
	localparam logic [7:0] T_INT32     = 8'h10;
	localparam logic [7:0] T_TIMESTAMP = 8'h11;
	localparam logic [7:0] T_INT64     = 8'h12;
	localparam logic [7:0] T_DECIMAL   = 8'h13;
	localparam logic [7:0] T_MAXKEY    = 8'h7F;
	localparam logic [7:0] T_MINKEY    = 8'hFF;

	typedef struct packed {
		logic       ok;
		logic [4:0] size;
	} fixed_size_t;

	// value size of the fixed-size types, ok low for unknown types
	function automatic fixed_size_t fixed_size(input logic [7:0] t);
		fixed_size_t r;
		r.ok   = 1'b1;
		r.size = 5'd0;
		unique case (t) inside
			T_DOUBLE, T_DATETIME, T_TIMESTAMP, T_INT64: r.size = 5'd8;
			T_BOOL:                                     r.size = 5'd1;
			T_NULL, T_MAXKEY, T_MINKEY:                 r.size = 5'd0;
			T_INT32:                                    r.size = 5'd4;
			T_DECIMAL:                                  r.size = 5'd16;
			T_OBJECTID:                                 r.size = 5'd12;
			default:                                    r.ok   = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bson_key_finder.sv =====
// bson_key_finder: streaming lookup of one element name in a bson document
// depends on bkf_pkg
`default_nettype none

// Document bytes enter on the s_axis channel, one byte per beat: tdata holds the byte,
// tuser marks the first byte (offset zero) of a new document and restarts the search at
// any time. The block reads the little-endian document size, then walks the elements,
// comparing each name with the key written on the cfg port (index 0 key bytes 0..7,
// index 1 key bytes 8..15, index 2 key length). Values are skipped by their size.
// One result beat on m_axis ends each search: tuser gives found, not found or
// malformed, tdata the type and the offsets of the matched element.
// A beat goes into an input register and is worked on from there once the output side
// does not stall, where a single pass of logic updates the walk state and loads the
// output register. A result is held in the output register on m_axis until it is taken.
// Throughput is one byte per cycle while no result is stalled in the output register.
// While a result waits in the output register the input register still takes one beat;
// further beats wait until the result is taken. Bytes outside a document are dropped.
// Reset clears the key and the walk: the block waits for a document start.
// The user must write keys only while no document is in flight; the block does not enforce it.
module bson_key_finder
	import bkf_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // doc_byte
	input  wire logic         s_axis_tuser,   // new_doc
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,   // elem_type, entry_offset, value_offset, zero pad
	output logic [1:0]        m_axis_tuser,   // status
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);

	// configuration
	logic [63:0] key_low_q, key_high_q;
	logic [4:0]  key_len_q;
	logic [KEY_W-1:0] key_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// walk state
	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q;
	logic [31:0]        doc_q;
	logic [7:0]         type_q;
	logic [4:0]         idx_q;
	logic               match_q;
	logic [31:0]        acc_q;
	logic [1:0]         cnt_q;
	logic [31:0]        skip_q;
	logic [OFFS_W-1:0]  elem_q;
	logic [33:0]        base_q;

	// output register
	logic              m_valid_q;
	logic [1:0]        m_status_q;
	logic [7:0]        m_type_q;
	logic [OFFS_W-1:0] m_entry_q, m_value_q;

	// step logic
	logic              step;
	phase_t            ph;
	logic [POS_W-1:0]  p;
	logic [1:0]        cnt;
	logic [32:0]       here;
	logic              doc_neg, p_past;
	logic [31:0]       len_full;
	logic              last_len, size_end;
	logic              key_miss, term, found, len_type;
	fixed_size_t       fix;
	logic [33:0]       fix_next, len_next;
	logic              fix_end, len_end, len_bad;
	logic [31:0]       rem_len;
	logic [33:0]       base_adj;

	logic              res_fire;
	logic [1:0]        res_status;
	logic [7:0]        res_type;
	logic [OFFS_W-1:0] res_entry, res_value;

	assign cfg_ready     = 1'b1;
	assign key_q         = {key_high_q, key_low_q};
	assign step          = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	// a start beat behaves as offset zero of the size field
	assign ph  = start_s1 ? PH_SIZE : phase_q;
	assign p   = start_s1 ? '0 : pos_q;
	assign cnt = start_s1 ? 2'd0 : cnt_q;

	assign here     = {1'b0, p} + 33'd1;
	assign doc_neg  = doc_q[31];
	assign p_past   = doc_neg || (p >= doc_q);
	assign len_full = {byte_s1, acc_q[23:0]};
	assign last_len = (cnt == 2'd3);
	assign size_end = len_full[31] || (here >= {1'b0, len_full});

	assign key_miss = (idx_q >= key_len_q) || idx_q[4]
		|| (key_q[{idx_q[3:0], 3'b000} +: 8] != byte_s1);
	assign term     = (byte_s1 == 8'h00);
	assign found    = match_q && (idx_q == key_len_q);
	assign len_type = (type_q >= T_STRING) && (type_q <= T_BINARY);

	assign fix      = fixed_size(type_q);
	assign fix_next = {1'b0, here} + {29'd0, fix.size};
	assign fix_end  = doc_neg || (fix_next >= {2'b00, doc_q});

	// base_q holds the offset after the length field plus the type's adjustment
	assign len_next = base_q + {2'b00, len_full};
	assign len_end  = doc_neg || (len_next >= {2'b00, doc_q});
	assign len_bad  = len_full[31]
		|| ((type_q != T_STRING) && (type_q != T_BINARY) && (len_full < 32'd4));

	always_comb begin
		case (type_q)
			T_STRING: rem_len = len_full;
			T_BINARY: rem_len = len_full + 32'd1;
			default:  rem_len = len_full - 32'd4;
		endcase
	end

	always_comb begin
		case (type_q)
			T_STRING: base_adj = 34'd2;
			T_BINARY: base_adj = 34'd3;
			default:  base_adj = 34'h3_FFFF_FFFE;
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			unique case (ph)
				PH_IDLE: phase_d = PH_IDLE;
				PH_SIZE: begin
					if (last_len) phase_d = size_end ? PH_IDLE : PH_TYPE;
					else          phase_d = PH_SIZE;
				end
				PH_TYPE: phase_d = term ? PH_IDLE : PH_NAME;
				PH_NAME: begin
					if (p_past)                   phase_d = PH_IDLE;
					else if (!term)               phase_d = PH_NAME;
					else if (found)               phase_d = PH_IDLE;
					else if (len_type)            phase_d = PH_LEN;
					else if (!fix.ok || fix_end)  phase_d = PH_IDLE;
					else if (fix.size != 5'd0)    phase_d = PH_SKIP;
					else                          phase_d = PH_TYPE;
				end
				PH_LEN: begin
					if (p_past)                   phase_d = PH_IDLE;
					else if (!last_len)           phase_d = PH_LEN;
					else if (len_bad || len_end)  phase_d = PH_IDLE;
					else if (rem_len != 32'd0)    phase_d = PH_SKIP;
					else                          phase_d = PH_TYPE;
				end
				PH_SKIP: phase_d = (skip_q <= 32'd1) ? PH_TYPE : PH_SKIP;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// result of the current byte
	always_comb begin
		res_fire   = 1'b0;
		res_status = ST_NOT_FOUND;
		res_type   = 8'h00;
		res_entry  = '0;
		res_value  = '0;
		unique case (ph)
			PH_SIZE: begin
				if (last_len && size_end) res_fire = 1'b1;
			end
			PH_TYPE: begin
				if (term) res_fire = 1'b1;
			end
			PH_NAME: begin
				if (p_past) begin
					res_fire   = 1'b1;
					res_status = ST_MALFORMED;
				end else if (term && found) begin
					res_fire   = 1'b1;
					res_status = ST_FOUND;
					res_type   = type_q;
					res_entry  = elem_q;
					res_value  = here[OFFS_W-1:0];
				end else if (term && !len_type) begin
					if (!fix.ok) begin
						res_fire   = 1'b1;
						res_status = ST_MALFORMED;
					end else if (fix_end) begin
						res_fire   = 1'b1;
					end
				end
			end
			PH_LEN: begin
				if (p_past) begin
					res_fire   = 1'b1;
					res_status = ST_MALFORMED;
				end else if (last_len && len_bad) begin
					res_fire   = 1'b1;
					res_status = ST_MALFORMED;
				end else if (last_len && len_end) begin
					res_fire   = 1'b1;
				end
			end
			default: res_fire = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LEN:  key_len_q  <= cfg_data[4:0];
				default:      key_len_q  <= key_len_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			doc_q   <= '0;
			idx_q   <= '0;
			match_q <= 1'b1;
			cnt_q   <= '0;
			skip_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (step && (ph != PH_IDLE)) begin
				pos_q <= p + 32'd1;
				unique case (ph)
					PH_SIZE: begin
						cnt_q <= cnt + 2'd1;
						if (last_len) doc_q <= len_full;
					end
					PH_TYPE: begin
						idx_q   <= '0;
						match_q <= 1'b1;
					end
					PH_NAME: begin
						if (!term) begin
							if (key_miss) match_q <= 1'b0;
							if (idx_q != 5'd31) idx_q <= idx_q + 5'd1;
						end else if (len_type) begin
							cnt_q <= '0;
						end else begin
							skip_q <= {27'd0, fix.size};
						end
					end
					PH_LEN: begin
						cnt_q <= cnt + 2'd1;
						if (last_len) skip_q <= rem_len;
					end
					PH_SKIP: begin
						if (skip_q != 32'd0) skip_q <= skip_q - 32'd1;
					end
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (step) begin
			if (ph == PH_SIZE || ph == PH_LEN)
				acc_q[{cnt, 3'b000} +: 8] <= byte_s1;
			if (ph == PH_LEN && !last_len)
				base_q <= {2'b00, p} + base_adj;
			if (ph == PH_TYPE) begin
				type_q <= byte_s1;
				elem_q <= p[OFFS_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && res_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_fire) begin
			m_status_q <= res_status;
			m_type_q   <= res_type;
			m_entry_q  <= res_entry;
			m_value_q  <= res_value;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {2'b00, m_value_q, m_entry_q, m_type_q};

`ifndef SYNTHESIS
	// a result always ends the walk
	a_result_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_fire |=> phase_q == PH_IDLE)
		else $error("walk continues after a result");

	a_found_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_FOUND |-> m_axis_tdata[7:0] != 8'h00)
		else $error("found result with zero type");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata == '0)
		else $error("non-found result carries payload");

	a_value_after_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_FOUND
		|-> m_axis_tdata[69:39] > m_axis_tdata[38:8])
		else $error("value offset not after entry offset");

	// a byte that waits in the input register is kept
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(byte_s1) && $stable(start_s1))
		else $error("input register lost a beat");
`endif

endmodule

`default_nettype wire

// ===== dv/bson_key_checker.sv =====
// bson_key_checker: predicts the lookup result of the documents fed to the bson key finder
// and compares it with the result beats; depends on bkf_pkg
module bson_key_checker
	import bkf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [71:0] m_axis_tdata,
	input  wire logic [1:0]  m_axis_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output int               fail_count,
	output int               lookups_pending,
	output int               bytes_walked
);

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  elem_type;
		logic [30:0] entry_offset;
		logic [30:0] value_offset;
	} lookup_t;

	lookup_t expected_lookups[$];

	// key registers as seen through the cfg channel
	logic [63:0] key_lo;
	logic [63:0] key_hi;
	logic [4:0]  key_len;

	// walk state
	phase_t      ph;
	logic [31:0] pos;
	logic [31:0] doc_size;
	logic [7:0]  cur_type;
	logic [4:0]  name_idx;
	logic        name_ok;
	logic [31:0] len_acc;
	logic [2:0]  len_cnt;
	logic [31:0] skip_left;
	logic [31:0] elem_start;

	function automatic longint sext32(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [7:0] key_at(input logic [4:0] i);
		logic [127:0] k;
		k = {key_hi, key_lo};
		return k[8 * i[3:0] +: 8];
	endfunction

	// bytes of value after the name for the fixed-size types, -1 for all other types
	function automatic int value_bytes(input logic [7:0] t);
		case (t)
			T_DOUBLE, T_DATETIME, T_TIMESTAMP, T_INT64: return 8;
			T_BOOL: return 1;
			T_NULL, T_MAXKEY, T_MINKEY: return 0;
			T_INT32: return 4;
			T_DECIMAL: return 16;
			T_OBJECTID: return 12;
			default: return -1;
		endcase
	endfunction

	task automatic report(input logic [1:0] st, input logic [7:0] ty, input logic [31:0] eo,
			input logic [31:0] vo);
		lookup_t r;
		r.status       = st;
		r.elem_type    = ty;
		r.entry_offset = eo[30:0];
		r.value_offset = vo[30:0];
		expected_lookups.push_back(r);
		ph = PH_IDLE;
	endtask

	// nxt: offset of the next type byte, rem: value bytes still to pass over
	task automatic at_boundary(input longint nxt, input longint rem);
		if (nxt >= sext32(doc_size)) begin
			report(ST_NOT_FOUND, 8'h00, 32'd0, 32'd0);
		end else if (rem > 0) begin
			skip_left = 32'(rem);
			ph = PH_SKIP;
		end else begin
			ph = PH_TYPE;
		end
	endtask

	task automatic walk_byte(input logic [7:0] b, input logic st);
		logic [31:0] p;
		longint here;
		longint len;
		longint rem;
		int n;
		if (st) begin
			ph = PH_SIZE;
			pos = 32'd0;
			len_acc = 32'd0;
			len_cnt = 3'd0;
		end
		if (ph == PH_IDLE)
			return;
		bytes_walked++;
		p = pos;
		pos = p + 32'd1;
		here = longint'(p) + 1;
		case (ph)
			PH_SIZE: begin
				len_acc = len_acc | ({24'd0, b} << (8 * len_cnt[1:0]));
				len_cnt = len_cnt + 3'd1;
				if (len_cnt >= 3'd4) begin
					doc_size = len_acc;
					at_boundary(here, 0);
				end
			end
			PH_TYPE: begin
				if (b == 8'h00) begin
					report(ST_NOT_FOUND, 8'h00, 32'd0, 32'd0);
				end else begin
					cur_type = b;
					elem_start = p;
					name_idx = 5'd0;
					name_ok = 1'b1;
					ph = PH_NAME;
				end
			end
			PH_NAME: begin
				if (longint'(p) >= sext32(doc_size)) begin
					report(ST_MALFORMED, 8'h00, 32'd0, 32'd0);
				end else if (b != 8'h00) begin
					if (name_idx >= key_len || name_idx >= MAX_KEY_BYTES || key_at(name_idx) != b)
						name_ok = 1'b0;
					if (name_idx < 5'd31)
						name_idx++;
				end else if (name_ok && name_idx == key_len) begin
					// a matching name wins before its type is looked at
					report(ST_FOUND, cur_type, elem_start, p + 32'd1);
				end else if (cur_type >= T_STRING && cur_type <= T_BINARY) begin
					len_acc = 32'd0;
					len_cnt = 3'd0;
					ph = PH_LEN;
				end else begin
					n = value_bytes(cur_type);
					if (n < 0)
						report(ST_MALFORMED, 8'h00, 32'd0, 32'd0);
					else
						at_boundary(here + n, n);
				end
			end
			PH_LEN: begin
				if (longint'(p) >= sext32(doc_size)) begin
					report(ST_MALFORMED, 8'h00, 32'd0, 32'd0);
					return;
				end
				len_acc = len_acc | ({24'd0, b} << (8 * len_cnt[1:0]));
				len_cnt = len_cnt + 3'd1;
				if (len_cnt < 3'd4)
					return;
				len = sext32(len_acc);
				if (len < 0) begin
					report(ST_MALFORMED, 8'h00, 32'd0, 32'd0);
					return;
				end
				if (cur_type == T_STRING) begin
					rem = len;
				end else if (cur_type == T_BINARY) begin
					rem = len + 1;    // subtype byte
				end else begin
					// document and array lengths count their own prefix
					if (len < 4) begin
						report(ST_MALFORMED, 8'h00, 32'd0, 32'd0);
						return;
					end
					rem = len - 4;
				end
				at_boundary(here + rem, rem);
			end
			PH_SKIP: begin
				if (skip_left > 32'd0)
					skip_left--;
				if (skip_left == 32'd0)
					ph = PH_TYPE;
			end
			default: ph = PH_IDLE;
		endcase
	endtask

	// sampled mid-cycle: a beat seen here is taken at the next rising edge
	always @(negedge clk) begin
		lookup_t got;
		lookup_t want;
		if (!arst_n) begin
			expected_lookups.delete();
			key_lo = 64'd0;
			key_hi = 64'd0;
			key_len = 5'd0;
			ph = PH_IDLE;
			pos = 32'd0;
			doc_size = 32'd0;
			cur_type = 8'h00;
			name_idx = 5'd0;
			name_ok = 1'b1;
			len_acc = 32'd0;
			len_cnt = 3'd0;
			skip_left = 32'd0;
			elem_start = 32'd0;
			fail_count = 0;
			lookups_pending = 0;
			bytes_walked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status       = m_axis_tuser;
				got.elem_type    = m_axis_tdata[7:0];
				got.entry_offset = m_axis_tdata[38:8];
				got.value_offset = m_axis_tdata[69:39];
				if (expected_lookups.size() == 0) begin
					$error("result beat with no lookup pending: status %0d", got.status);
					fail_count++;
				end else begin
					want = expected_lookups.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.elem_type !== want.elem_type) begin
						$error("elem_type: expected %0h, got %0h", want.elem_type, got.elem_type);
						fail_count++;
					end
					if (got.entry_offset !== want.entry_offset) begin
						$error("entry_offset: expected %0d, got %0d", want.entry_offset,
							got.entry_offset);
						fail_count++;
					end
					if (got.value_offset !== want.value_offset) begin
						$error("value_offset: expected %0d, got %0d", want.value_offset,
							got.value_offset);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KEY_LOW:  key_lo = cfg_data;
					CFG_KEY_HIGH: key_hi = cfg_data;
					CFG_KEY_LEN:  key_len = cfg_data[4:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				walk_byte(s_axis_tdata, s_axis_tuser);
			lookups_pending = expected_lookups.size();
		end
	end

endmodule

// ===== dv/bson_key_finder_test.sv =====
// bson_key_finder_test: feeds directed and random bson documents through the key finder
// under changing keys and flow control; depends on bkf_pkg, bson_key_finder and bson_key_checker
module bson_key_finder_test
	import bkf_pkg::*;
();

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // doc_byte
	logic        s_axis_tuser = 1'b0;    // new_doc
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;           // elem_type, entry_offset, value_offset, zero pad
	logic [1:0]  m_axis_tuser;           // status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_KEY_LOW;
	logic [63:0] cfg_data = 64'd0;

	int fail_count;
	int lookups_pending;
	int bytes_walked;

	bit   hold_req = 1'b0;
	int   burst_left = 0;
	bit   no_gaps = 1'b0;
	logic [7:0]   doc_q[$];
	logic [127:0] key_img = '0;
	int           key_n = 0;

	logic [7:0] fixed_types [11] = '{T_DOUBLE, T_DATETIME, T_TIMESTAMP, T_INT64, T_BOOL,
		T_NULL, T_MAXKEY, T_MINKEY, T_INT32, T_DECIMAL, T_OBJECTID};
	int         fixed_len [11] = '{8, 8, 8, 8, 1, 0, 0, 0, 4, 16, 12};

	bson_key_finder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	bson_key_checker u_lookup_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.lookups_pending (lookups_pending),
		.bytes_walked    (bytes_walked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("bson_key_finder test failed");
		$finish;
	end

	// result side: stall pattern of its own, with one long hold-off on request
	initial begin
		int span;
		int pct;
		span = 0;
		pct = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (120) @(posedge clk);
			end
			if (span == 0) begin
				span = $urandom_range(10, 150);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 30;
					2: pct = 60;
					default: pct = 92;
				endcase
			end
			span--;
			m_axis_tready <= ($urandom_range(0, 99) >= pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		logic hs;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= st;
		do begin
			@(negedge clk);
			hs = s_axis_tready;
			@(posedge clk);
		end while (!hs);
	endtask

	task automatic send_doc(input int cut);
		for (int i = 0; i < cut; i++)
			send_byte(doc_q[i], i == 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		logic hs;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			hs = cfg_ready;
			@(posedge clk);
		end while (!hs);
	endtask

	// stop feeding, wait for every lookup to come back and the pipe to empty
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (lookups_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_le(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			doc_q.push_back(v[8 * i +: 8]);
	endtask

	task automatic add_element(input bit bad);
		int pick;
		int bad_kind;
		int nm;
		int klen;
		int vl;
		logic [7:0] t;
		pick = $urandom_range(0, 14);
		bad_kind = $urandom_range(0, 2);
		if (bad) begin
			if (bad_kind == 0)
				t = 8'($urandom_range(8'h14, 8'h7E));
			else if (bad_kind == 1)
				t = T_STRING;
			else
				t = $urandom_range(0, 1) ? T_ARRAY : T_DOCUMENT;
		end else if (pick < 11) begin
			t = fixed_types[pick];
		end else begin
			case (pick)
				11: t = T_STRING;
				12: t = T_DOCUMENT;
				13: t = T_ARRAY;
				default: t = T_BINARY;
			endcase
		end
		doc_q.push_back(t);

		// name: the key, a near miss of it, or something random
		nm = $urandom_range(0, 9);
		klen = (key_n > 16) ? 16 : key_n;
		if (nm <= 4 || nm == 6) begin
			for (int i = 0; i < klen; i++)
				doc_q.push_back(key_img[8 * i +: 8]);
			if (nm == 4 && klen > 0)
				doc_q[doc_q.size() - 1 - $urandom_range(0, klen - 1)] ^=
					8'h01 << $urandom_range(0, 7);
			if (nm == 6)
				doc_q.push_back(8'($urandom_range(1, 255)));
		end else if (nm == 5) begin
			for (int i = 0; i < klen - 1; i++)
				doc_q.push_back(key_img[8 * i +: 8]);
		end else begin
			repeat ($urandom_range(0, 6)) doc_q.push_back(8'($urandom_range(1, 255)));
		end
		doc_q.push_back(8'h00);

		if (bad) begin
			if (bad_kind == 0)
				repeat ($urandom_range(0, 3)) doc_q.push_back(8'($urandom_range(0, 255)));
			else if (bad_kind == 1)
				push_le(32'h8000_0000 | $urandom());
			else
				push_le($urandom_range(0, 3));
		end else if (pick < 11) begin
			repeat (fixed_len[pick]) doc_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			vl = $urandom_range(0, 6);
			if (t == T_STRING) begin
				push_le(vl);
			end else if (t == T_BINARY) begin
				push_le(vl);
				doc_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				push_le(vl + 4);
			end
			repeat (vl) doc_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic build_doc();
		int flaw;
		int n_elem;
		logic [31:0] sz;
		flaw = $urandom_range(0, 9);
		n_elem = $urandom_range(0, 4);
		doc_q.delete();
		push_le(32'd0);
		for (int e = 0; e < n_elem; e++)
			add_element(flaw == 7 && e == n_elem - 1);
		doc_q.push_back(8'h00);
		sz = doc_q.size();
		if (flaw == 8)
			sz = $urandom_range(0, sz);    // size field no longer than the document
		else if (flaw == 9)
			sz = $urandom();
		for (int i = 0; i < 4; i++)
			doc_q[i] = sz[8 * i +: 8];
		if ($urandom_range(0, 19) == 0)
			doc_q[$urandom_range(0, doc_q.size() - 1)] = 8'($urandom_range(0, 255));
	endtask

	task automatic load_key(input int ph_no);
		logic [63:0] len_word;
		for (int i = 0; i < 16; i++)
			key_img[8 * i +: 8] = 8'($urandom_range(1, 255));
		case (ph_no)
			0: begin
				key_img = '1;
				key_n = 16;
			end
			1: key_n = 0;
			2: key_n = 20;    // longer than the key store, never matches
			3: begin
				key_img[8 * 2 +: 8] = 8'h00;
				key_n = 5;
			end
			4: begin
				key_img[7:0] = 8'h01;
				key_n = 1;
			end
			5: key_n = 31;
			default: begin
				case ($urandom_range(0, 7))
					0: key_n = $urandom_range(7, 16);
					1: key_n = $urandom_range(17, 31);
					default: key_n = $urandom_range(1, 6);
				endcase
			end
		endcase
		len_word = {$urandom(), $urandom()};
		len_word[4:0] = 5'(key_n);
		write_reg(CFG_KEY_LOW, key_img[63:0]);
		write_reg(CFG_KEY_HIGH, key_img[127:64]);
		write_reg(CFG_KEY_LEN, len_word);
		if (ph_no == 1)
			write_reg(CFG_UNUSED, {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int phase_no;
		int cut;
		int goal;
		bit paused;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key: length zero, so an empty name matches
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		doc_q = '{8'h02, 8'h00, 8'h00, 8'h00};
		send_doc(4);
		doc_q = '{8'h0C, 8'h00, 8'h00, 8'h00, 8'h10};
		send_doc(5);
		doc_q = '{8'h0C, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00};
		send_doc(6);
		doc_q = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00};
		send_doc(5);
		doc_q = '{8'h08, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00};
		send_doc(6);
		wait_drained();

		phase_no = 0;
		paused = 1'b0;
		while (bytes_walked < 500) begin
			load_key(phase_no);
			no_gaps = ($urandom_range(0, 2) == 0);
			if (phase_no % 4 == 2)
				hold_req = 1'b1;
			goal = bytes_walked + 50;
			while (bytes_walked < goal) begin
				build_doc();
				cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, doc_q.size()) : doc_q.size();
				send_doc(cut);
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
				if (phase_no == 3 && !paused) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			wait_drained();
			phase_no++;
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && lookups_pending == 0)
			$display("bson_key_finder test passed");
		else
			$display("bson_key_finder test failed");
		$finish;
	end

endmodule

// ===== bson_key_finder.f =====
hw/rtl/bkf_pkg.sv
hw/rtl/bson_key_finder.sv
dv/bson_key_checker.sv
dv/bson_key_finder_test.sv
